### sv/cdsct_pkg.sv
package cdsct_pkg;

    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 3;

    // register index, taken from paddr[2]
    localparam logic REG_DIRECTION = 1'b0;

    localparam logic DIR_DEINTERLEAVE = 1'b0;
    localparam logic DIR_INTERLEAVE   = 1'b1;

    localparam int unsigned WORD_IDX_W = 4;

    typedef logic [7:0]  byte_t;
    typedef logic [63:0] word_t;

endpackage

### sv/cdsct_byte_cell.sv
module cdsct_byte_cell
(
    input  logic                 clk,
    input  logic                 shift_en,
    input  cdsct_pkg::byte_t     d_in,
    output cdsct_pkg::byte_t     q
);

    cdsct_pkg::byte_t data_reg;
    cdsct_pkg::byte_t data_next;

    always_comb
    begin
        data_next = shift_en ? d_in : data_reg;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### sv/cdsct_word_cell.sv
module cdsct_word_cell
(
    input  logic                 clk,
    input  logic                 load_en,
    input  logic                 shift_en,
    input  cdsct_pkg::word_t     load_d,
    input  cdsct_pkg::word_t     shift_d,
    output cdsct_pkg::word_t     q
);

    cdsct_pkg::word_t data_reg;
    cdsct_pkg::word_t data_next;

    always_comb
    begin
        if (load_en)
        begin
            data_next = load_d;
        end
        else if (shift_en)
        begin
            data_next = shift_d;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

### sv/cd_subcode_channel_transpose_top.sv
// Bytes enter a row of byte cells, one per cycle while in_ready is high; a full block
// is transposed by wiring and loaded into a row of word cells that shift out one word
// per cycle while out_ready is high. Accepting the final byte sets the pending flag;
// the block then loads into the word cells, raising out_valid. in_ready is low while a
// block is pending, and the load waits until the previous block's words have drained.
// Reset (rst_n, async): byte count, load flag, word count and direction cleared.
module cd_subcode_channel_transpose_top #(
    parameter int unsigned BLOCK_BYTES = 96
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [cdsct_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cdsct_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cdsct_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [7:0]                            in_byte,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [63:0]                           out_word,
    output logic [cdsct_pkg::WORD_IDX_W-1:0]      word_index,
    output logic                                  last_word
);

    localparam int unsigned CH_BYTES  = BLOCK_BYTES / 8;
    localparam int unsigned FULL      = CH_BYTES * 8;
    localparam int unsigned CNT_W     = $clog2(FULL);
    localparam int unsigned OCNT_W    = $clog2(CH_BYTES + 1);
    localparam int unsigned IDX_W     = $clog2(CH_BYTES);

    // configuration
    logic direction_reg;
    logic direction_next;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cdsct_pkg::REG_DIRECTION);

    always_comb
    begin
        direction_next = cfg_wr ? pwdata[0] : direction_reg;
        prdata         = '0;
        if (paddr[2] == cdsct_pkg::REG_DIRECTION)
        begin
            prdata[0] = direction_reg;
        end
    end

    // input side control
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pend_reg;
    logic              pend_next;
    logic              in_acc;
    logic              load_en;

    logic [OCNT_W-1:0] ocnt_reg;
    logic [OCNT_W-1:0] ocnt_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              out_acc;

    assign in_ready  = !pend_reg;
    assign in_acc    = in_valid && in_ready;
    assign out_valid = (ocnt_reg != '0);
    assign out_acc   = out_valid && out_ready;
    assign load_en   = pend_reg && (ocnt_reg == '0);

    always_comb
    begin
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (in_acc)
        begin
            if (cnt_reg == CNT_W'(FULL - 1))
            begin
                cnt_next  = '0;
                pend_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (load_en)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        ocnt_next = ocnt_reg;
        idx_next  = idx_reg;
        if (load_en)
        begin
            ocnt_next = OCNT_W'(CH_BYTES);
            idx_next  = '0;
        end
        else if (out_acc)
        begin
            ocnt_next = ocnt_reg - 1'b1;
            idx_next  = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= cdsct_pkg::DIR_DEINTERLEAVE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            ocnt_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            direction_reg <= direction_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            ocnt_reg      <= ocnt_next;
            idx_reg       <= idx_next;
        end
    end

    // byte row: byte n of the block ends up in cell n
    cdsct_pkg::byte_t store_q [FULL];

    genvar gi, gb;
    generate
        for (gi = 0; gi < FULL; gi++)
        begin : g_byte
            cdsct_pkg::byte_t d_in;
            if (gi == FULL - 1)
            begin : g_tail
                assign d_in = in_byte;
            end
            else
            begin : g_mid
                assign d_in = store_q[gi + 1];
            end
            cdsct_byte_cell u_cell (
                .clk      (clk),
                .shift_en (in_acc),
                .d_in     (d_in),
                .q        (store_q[gi])
            );
        end
    endgenerate

    // transpose is pure wiring
    cdsct_pkg::byte_t deint_b [FULL];
    cdsct_pkg::byte_t inter_b [FULL];

    generate
        for (gi = 0; gi < FULL; gi++)
        begin : g_conv
            for (gb = 0; gb < 8; gb++)
            begin : g_bit
                assign deint_b[gi][7 - gb] =
                    store_q[8 * (gi % CH_BYTES) + gb][7 - (gi / CH_BYTES)];
                assign inter_b[gi][7 - gb] =
                    store_q[gb * CH_BYTES + (gi / 8)][7 - (gi % 8)];
            end
        end
    endgenerate

    // word row: cell 0 drives the output
    cdsct_pkg::word_t word_q [CH_BYTES];

    generate
        for (gi = 0; gi < CH_BYTES; gi++)
        begin : g_word
            cdsct_pkg::word_t load_d;
            cdsct_pkg::word_t shift_d;
            for (gb = 0; gb < 8; gb++)
            begin : g_lane
                assign load_d[63 - 8 * gb -: 8] =
                    (direction_reg == cdsct_pkg::DIR_INTERLEAVE) ?
                    inter_b[8 * gi + gb] : deint_b[8 * gi + gb];
            end
            if (gi == CH_BYTES - 1)
            begin : g_tail
                assign shift_d = '0;
            end
            else
            begin : g_mid
                assign shift_d = word_q[gi + 1];
            end
            cdsct_word_cell u_cell (
                .clk      (clk),
                .load_en  (load_en),
                .shift_en (out_acc),
                .load_d   (load_d),
                .shift_d  (shift_d),
                .q        (word_q[gi])
            );
        end
    endgenerate

    assign out_word   = word_q[0];
    assign word_index = cdsct_pkg::WORD_IDX_W'(idx_reg);
    assign last_word  = (ocnt_reg == OCNT_W'(1));

endmodule

### sv/cdsct_checker.sv
module cdsct_checker #(
    parameter int unsigned BLOCK_BYTES = 96
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [63:0]                       out_word,
    input  logic [cdsct_pkg::WORD_IDX_W-1:0]  word_index,
    input  logic                              last_word
);

    localparam int unsigned CH_BYTES = BLOCK_BYTES / 8;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("output item changed while stalled");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_word |-> word_index == cdsct_pkg::WORD_IDX_W'(CH_BYTES - 1))
        else $error("last word at wrong index");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_word |=>
            out_valid && word_index == $past(word_index) + 1'b1)
        else $error("words of a block not contiguous");

    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && last_word |=> !out_valid)
        else $error("output valid right after last word");

    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> word_index == '0)
        else $error("block does not start at word zero");

endmodule

bind cd_subcode_channel_transpose_top cdsct_checker #(
    .BLOCK_BYTES (BLOCK_BYTES)
) u_cdsct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .word_index (word_index),
    .last_word  (last_word)
);

### verif/cd_subcode_channel_transpose_top_tb.sv
module cd_subcode_channel_transpose_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BLK      = 96;
    localparam int unsigned CH_BYTES = BLK / 8;
    localparam int unsigned SETTLE   = 4;

    localparam logic [cdsct_pkg::APB_ADDR_W-1:0] ADDR_DIRECTION =
        {cdsct_pkg::REG_DIRECTION, 2'b00};
    localparam logic [cdsct_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED  =
        {~cdsct_pkg::REG_DIRECTION, 2'b00};

    typedef struct packed {
        cdsct_pkg::word_t                 word;
        logic [cdsct_pkg::WORD_IDX_W-1:0] idx;
        logic                             last;
    } word_item_t;

    logic                             clk = 1'b0;
    logic                             rst_n;

    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [cdsct_pkg::APB_ADDR_W-1:0] paddr;
    logic [cdsct_pkg::APB_DATA_W-1:0] pwdata;
    logic [cdsct_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    logic                             in_valid;
    logic                             in_ready;
    logic [7:0]                       in_byte;

    logic                             out_valid;
    logic                             out_ready;
    logic [63:0]                      out_word;
    logic [cdsct_pkg::WORD_IDX_W-1:0] word_index;
    logic                             last_word;

    // predictor state
    cdsct_pkg::byte_t      src_bytes [BLK];
    int unsigned           src_fill;
    logic                  dir_shadow;
    word_item_t            pending_words [$];

    int unsigned           mismatches;
    bit                    tx_idle_on;
    bit                    rx_idle_on;
    int                    hold_req;
    int                    hold_left;
    int                    rx_gap;

    cd_subcode_channel_transpose_top #(
        .BLOCK_BYTES (BLK)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_word   (out_word),
        .word_index (word_index),
        .last_word  (last_word)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, want, got);
    endtask

    // Transpose the stored block and queue its words.
    task automatic transpose_block();
        cdsct_pkg::byte_t conv [BLK];
        word_item_t       w;
        for (int i = 0; i < BLK; i++)
            conv[i] = '0;
        for (int k = 0; k < CH_BYTES; k++)
        begin
            for (int j = 0; j < 8; j++)
            begin
                for (int ch = 0; ch < 8; ch++)
                begin
                    if (dir_shadow == cdsct_pkg::DIR_DEINTERLEAVE)
                        conv[ch*CH_BYTES + k][7-j] = src_bytes[8*k + j][7-ch];
                    else
                        conv[8*k + j][7-ch] = src_bytes[ch*CH_BYTES + k][7-j];
                end
            end
        end
        for (int wi = 0; wi < CH_BYTES; wi++)
        begin
            w.word = '0;
            for (int b = 0; b < 8; b++)
                w.word = {w.word[55:0], conv[8*wi + b]};
            w.idx  = wi[cdsct_pkg::WORD_IDX_W-1:0];
            w.last = (wi == CH_BYTES - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic absorb_byte(input cdsct_pkg::byte_t b);
        src_bytes[src_fill] = b;
        src_fill++;
        if (src_fill == BLK)
        begin
            src_fill = 0;
            transpose_block();
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        word_item_t head;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
                note_mismatch("unexpected word", '0, out_word);
            else
            begin
                head = pending_words.pop_front();
                if (out_word !== head.word)
                    note_mismatch("out_word", head.word, out_word);
                if (word_index !== head.idx)
                    note_mismatch("word_index", 64'(head.idx), 64'(word_index));
                if (last_word !== head.last)
                    note_mismatch("last_word", 64'(head.last), 64'(last_word));
            end
        end
    end

    // Receiver: random gaps, plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_req > 0)
        begin
            hold_left = hold_req - 1;
            hold_req  = 0;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (rx_idle_on)
                rx_gap = pick_gap();
        end
    end

    task automatic apb_write(input logic [cdsct_pkg::APB_ADDR_W-1:0] addr,
                             input logic [cdsct_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_DIRECTION)
            dir_shadow = data[0];
        @(posedge clk);
    endtask

    task automatic apb_read(input logic [cdsct_pkg::APB_ADDR_W-1:0] addr,
                            output logic [cdsct_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_direction(input logic dir);
        logic [cdsct_pkg::APB_DATA_W-1:0] rd;
        apb_write(ADDR_DIRECTION, {31'($urandom()), dir});
        apb_read(ADDR_DIRECTION, rd);
        if (rd !== {{(cdsct_pkg::APB_DATA_W-1){1'b0}}, dir_shadow})
            note_mismatch("direction readback", 64'(dir_shadow), 64'(rd));
    endtask

    // Sends one item; valid stays high when no gap follows.
    task automatic send_byte(input cdsct_pkg::byte_t b);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_byte(b);
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_register_access();
        logic [cdsct_pkg::APB_DATA_W-1:0] rd;
        apb_read(ADDR_DIRECTION, rd);
        if (rd !== {{(cdsct_pkg::APB_DATA_W-1){1'b0}}, cdsct_pkg::DIR_DEINTERLEAVE})
            note_mismatch("direction after reset", 64'(cdsct_pkg::DIR_DEINTERLEAVE),
                          64'(rd));
        apb_write(ADDR_UNMAPPED, '1);
        apb_read(ADDR_DIRECTION, rd);
        if (rd !== {{(cdsct_pkg::APB_DATA_W-1){1'b0}}, dir_shadow})
            note_mismatch("direction after unmapped write", 64'(dir_shadow), 64'(rd));
        set_direction(cdsct_pkg::DIR_INTERLEAVE);
        set_direction(cdsct_pkg::DIR_DEINTERLEAVE);
    endtask

    task automatic test_directed_blocks();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_direction(cdsct_pkg::DIR_DEINTERLEAVE);
        for (int i = 0; i < BLK; i++)
            send_byte(8'h80 >> (i % 8));
        drain_results();
    endtask

    task automatic test_direction_mid_block();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_direction(cdsct_pkg::DIR_DEINTERLEAVE);
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain_results();
        apb_write(ADDR_UNMAPPED, $urandom());
        set_direction(cdsct_pkg::DIR_INTERLEAVE);
        for (int i = 40; i < BLK; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        set_direction(1'($urandom_range(0, 1)));
        hold_req   = 400;
        for (int i = 0; i < 2 * BLK; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    // A trailing partial block must produce no words.
    task automatic test_partial_block();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_direction(1'($urandom_range(0, 1)));
        for (int i = 0; i < BLK / 2; i++)
            send_byte(8'($urandom_range(0, 255)));
        drain_results();
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        in_valid   <= 1'b0;
        in_byte    <= '0;
        out_ready  <= 1'b0;
        src_fill   = 0;
        dir_shadow = cdsct_pkg::DIR_DEINTERLEAVE;
        mismatches = 0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 0;
        hold_left  = 0;
        rx_gap     = 0;
        for (int i = 0; i < BLK; i++)
            src_bytes[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_directed_blocks();
        test_direction_mid_block();
        test_output_backpressure();
        test_partial_block();

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_words.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
